/* src/srbt_pkg.sv */
// Shared types, constants and helper functions for the segment receipt bitmap tracker.
// Used by the channel interfaces and the tracker core; depends on nothing else.
package srbt_pkg;

  // Default bitmap depth in bytes (legal range 1 to 256).
  localparam int unsigned BitmapBytesDefault = 64;

  // Field widths fixed by the request and result formats.
  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned SegIndexW = 9;
  localparam int unsigned BytePosW  = 6;
  localparam int unsigned TotalW    = 10;
  localparam int unsigned CountW    = 10;
  localparam int unsigned NextW     = 10;

  // Request codes.
  typedef enum logic [ReqTypeW-1:0] {
    REQ_MARK      = 2'd0,
    REQ_CLEAR_TWO = 2'd1,
    REQ_CLEAR_ALL = 2'd2,
    REQ_QUERY     = 2'd3
  } req_type_e;

  // Configuration register indexes.
  localparam int unsigned RegTotal    = 0;
  localparam int unsigned RegNearDone = 1;
  localparam int unsigned ApbAddrW    = 3;

  // A bitmap byte with every segment received.
  localparam logic [7:0] ByteFull = 8'hFF;

  // floor(y/5) for y below 256 is (y*205) >> 10.
  localparam logic [7:0] DivFiveMul   = 8'd205;
  localparam int unsigned DivFiveShift = 10;

  // Number of set bits in one bitmap byte.
  function automatic logic [3:0] byte_popcount(input logic [7:0] b);
    logic [3:0] acc;
    acc = 4'd0;
    for (int k = 0; k < 8; k++) begin
      acc = acc + {3'd0, b[k]};
    end
    return acc;
  endfunction

  // Position of the lowest clear bit of a byte that is not full.
  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!b[k]) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

endpackage

/* src/srbt_if.sv */
// Request and result channel interfaces of the segment receipt bitmap tracker.
// Depends on srbt_pkg for the field widths.
interface srbt_req_if;
  logic                              valid;
  logic                              ready;
  logic [srbt_pkg::ReqTypeW-1:0]     req_type;
  logic [srbt_pkg::SegIndexW-1:0]    seg_index;
  logic                              write_ok;
  logic [srbt_pkg::BytePosW-1:0]     byte_pos;

  modport source (output valid, req_type, seg_index, write_ok, byte_pos, input ready);
  modport sink   (input valid, req_type, seg_index, write_ok, byte_pos, output ready);
endinterface

interface srbt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              already_received;
  logic                              erase_request;
  logic                              vector_ready;
  logic [srbt_pkg::CountW-1:0]       received_count;
  logic                              all_complete;
  logic                              near_done;
  logic                              next_found;
  logic [srbt_pkg::NextW-1:0]        next_missing_index;

  modport source (output valid, already_received, erase_request, vector_ready,
                  received_count, all_complete, near_done, next_found,
                  next_missing_index, input ready);
  modport sink   (input valid, already_received, erase_request, vector_ready,
                  received_count, all_complete, near_done, next_found,
                  next_missing_index, output ready);
endinterface

/* src/segment_receipt_bitmap_tracker_core.sv */
// Top level of the segment receipt bitmap tracker: bitmap memory, scan sequencer, APB registers.
// Depends on srbt_pkg and the srbt_req_if / srbt_rsp_if channel interfaces.
//
// Usage:
//   Requests arrive on req_i (valid/ready); a transfer happens when both are high.
//   Each request yields exactly one result on rsp_o (valid/ready).
//   Mark requests read the segment's bitmap byte and write it back in the next cycle;
//   clear requests drop the per-byte valid bits, so cleared bytes read as zero.
//   Every request then scans the whole bitmap, one byte per cycle through a single
//   read port, accumulating the popcount, completion and first missing segment.
// Request pacing:
//   req_i.ready returns in the same cycle in which the result is first offered,
//   so a new request is taken only once the last one has been scanned; the byte
//   scan over the single memory port sets the pace of requests.
// Stalls: the result waits in an output register; the next request is accepted and
//   scanned meanwhile, and the sequencer holds at its final step until that
//   register frees up.
// Reset: the bitmap reads as all zeros at once (per-byte valid bits are cleared),
//   both configuration registers return to zero, and no result is pending.
// Configuration: APB, total_segments at 0x0, near_done_enable at 0x4; write only
//   while no request is in flight.
module segment_receipt_bitmap_tracker_core #(
  parameter int unsigned BITMAP_BYTES = srbt_pkg::BitmapBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  srbt_req_if.sink                      req_i,
  srbt_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srbt_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned IdxW  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned NbW   = $clog2(BITMAP_BYTES + 1);
  localparam int unsigned CntW  = $clog2(8 * BITMAP_BYTES + 1);
  localparam int unsigned CmpW  = (CntW > srbt_pkg::TotalW) ? CntW : srbt_pkg::TotalW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BITMAP_BYTES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Configuration registers.
  logic [srbt_pkg::TotalW-1:0] total_q;
  logic                        nde_q;

  // Sequencer and per-request registers.
  state_e                      state_q;
  logic [BITMAP_BYTES-1:0]     valid_q;
  logic [srbt_pkg::SegIndexW-1:0] seg_q;
  logic                        wok_q;
  logic                        inrange_q;
  logic [IdxW-1:0]             scan_q;
  logic                        pend_q;
  logic [IdxW-1:0]             pend_idx_q;
  logic [NbW-1:0]              nbytes_q;
  logic [CntW-1:0]             count_q;
  logic                        complete_q;
  logic                        found_q;
  logic [srbt_pkg::NextW-1:0]  next_q;
  logic                        already_q;
  logic                        erase_q;
  logic                        vec_q;

  // Memory read port.
  logic [7:0]                  mem_q [BITMAP_BYTES];
  logic [7:0]                  rd_data_q;
  logic                        rd_vld_q;

  // Output register.
  logic                        out_vld_q;
  logic                        o_already_q, o_erase_q, o_vec_q;
  logic [srbt_pkg::CountW-1:0] o_count_q;
  logic                        o_complete_q, o_near_q, o_found_q;
  logic [srbt_pkg::NextW-1:0]  o_next_q;

  logic                        req_xfer;
  logic [8:0]                  seg_byte;
  logic                        seg_inr;
  logic [IdxW-1:0]             rd_addr;
  logic [7:0]                  cur_byte;
  logic                        cur_bit;
  logic                        wr_en;
  logic [7:0]                  wr_data;
  logic [IdxW-1:0]             seg_idx;
  logic                        load;
  logic                        tail_found;
  logic [15:0]                 thr_prod;
  logic [CmpW-1:0]             thr_w;
  logic [CmpW-1:0]             total_w;
  logic [CmpW-1:0]             count_w;
  logic [CmpW-1:0]             remain_w;
  logic [srbt_pkg::TotalW-1:0] nb_full;
  logic [7:0]                  scan_byte;
  logic                        in_scope;
  logic [10:0]                 next_sum;
  logic [8:0]                  pos_lo;
  logic [8:0]                  pos_hi;

  // APB register port: always ready, writes on the access phase.
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2]) begin
      prdata = {31'd0, nde_q};
    end else begin
      prdata = {{(32 - srbt_pkg::TotalW){1'b0}}, total_q};
    end
  end

  // Byte addressing of the incoming request.
  assign req_xfer = req_i.valid && req_i.ready;
  assign seg_byte = {3'd0, req_i.seg_index[srbt_pkg::SegIndexW-1:3]};
  assign seg_inr  = (32'(seg_byte) < BITMAP_BYTES);
  assign rd_addr  = (state_q == ST_IDLE) ? seg_byte[IdxW-1:0] : scan_q;
  assign pos_lo   = {3'd0, req_i.byte_pos};
  assign pos_hi   = pos_lo + 9'd1;
  assign seg_idx  = IdxW'({3'd0, seg_q[srbt_pkg::SegIndexW-1:3]});

  // A byte whose valid bit is clear reads as zero.
  assign cur_byte = rd_vld_q ? rd_data_q : 8'd0;
  assign cur_bit  = inrange_q && cur_byte[seg_q[2:0]];

  // Mark update: write the byte back with the segment's bit set.
  assign wr_en   = (state_q == ST_MARK) && !cur_bit &&
                   ({1'b0, seg_q} != total_q) && wok_q && inrange_q;
  assign wr_data = cur_byte | (8'd1 << seg_q[2:0]);

  // Per-byte scan step: popcount, completion and first clear bit.
  assign scan_byte = cur_byte;
  assign in_scope  = ({{(32 - IdxW){1'b0}}, pend_idx_q} < 32'(nbytes_q));
  assign next_sum  = 11'({pend_idx_q, srbt_pkg::first_zero(scan_byte)}) + 11'd1;

  // Final step: near-done threshold floor(total/20) and the all-set tail case.
  assign nb_full    = {3'd0, total_q[srbt_pkg::TotalW-1:3]};
  assign tail_found = (total_q != '0) && (total_q[2:0] == 3'd0) &&
                      (32'(nb_full) <= BITMAP_BYTES);
  assign thr_prod   = {8'd0, total_q[srbt_pkg::TotalW-1:2]} * {8'd0, srbt_pkg::DivFiveMul};
  assign thr_w      = CmpW'(thr_prod >> srbt_pkg::DivFiveShift);
  assign total_w    = CmpW'(total_q);
  assign count_w    = CmpW'(count_q);
  assign remain_w   = (count_w >= total_w) ? '0 : (total_w - count_w);
  assign load       = (state_q == ST_FIN) && !pend_q && (!out_vld_q || rsp_o.ready);

  assign req_i.ready = (state_q == ST_IDLE);

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[seg_idx] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer, valid bits, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      total_q      <= '0;
      nde_q        <= 1'b0;
      valid_q      <= '0;
      rd_vld_q     <= 1'b0;
      pend_q       <= 1'b0;
      out_vld_q    <= 1'b0;
      scan_q       <= '0;
      pend_idx_q   <= '0;
      seg_q        <= '0;
      wok_q        <= 1'b0;
      inrange_q    <= 1'b0;
      nbytes_q     <= '0;
      count_q      <= '0;
      complete_q   <= 1'b1;
      found_q      <= 1'b0;
      next_q       <= '0;
      already_q    <= 1'b0;
      erase_q      <= 1'b0;
      vec_q        <= 1'b0;
      o_already_q  <= 1'b0;
      o_erase_q    <= 1'b0;
      o_vec_q      <= 1'b0;
      o_count_q    <= '0;
      o_complete_q <= 1'b0;
      o_near_q     <= 1'b0;
      o_found_q    <= 1'b0;
      o_next_q     <= '0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite) begin
        if (paddr[2] == 1'(srbt_pkg::RegNearDone)) begin
          nde_q <= pwdata[0];
        end else begin
          total_q <= pwdata[srbt_pkg::TotalW-1:0];
        end
      end

      rd_vld_q <= valid_q[rd_addr];

      // Result transfer frees the output register unless a new result loads.
      if (rsp_o.ready && !load) begin
        out_vld_q <= 1'b0;
      end

      // Scan data arrives in the cycle after its read was issued.
      pend_q <= (state_q == ST_SCAN);
      pend_idx_q <= scan_q;
      if (pend_q) begin
        count_q <= count_q + CntW'(srbt_pkg::byte_popcount(scan_byte));
        if (in_scope && (scan_byte != srbt_pkg::ByteFull)) begin
          complete_q <= 1'b0;
          if (!found_q) begin
            found_q <= 1'b1;
            next_q  <= next_sum[srbt_pkg::NextW-1:0];
          end
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (req_xfer) begin
            seg_q      <= req_i.seg_index;
            wok_q      <= req_i.write_ok;
            inrange_q  <= seg_inr;
            scan_q     <= '0;
            count_q    <= '0;
            complete_q <= 1'b1;
            found_q    <= 1'b0;
            next_q     <= '0;
            already_q  <= 1'b0;
            erase_q    <= 1'b0;
            vec_q      <= 1'b0;
            nbytes_q   <= (32'(nb_full) > BITMAP_BYTES) ? NbW'(BITMAP_BYTES)
                                                        : NbW'(nb_full);
            case (srbt_pkg::req_type_e'(req_i.req_type))
              srbt_pkg::REQ_MARK: begin
                state_q <= ST_MARK;
              end
              srbt_pkg::REQ_CLEAR_TWO: begin
                if (32'(pos_lo) < BITMAP_BYTES) begin
                  valid_q[pos_lo[IdxW-1:0]] <= 1'b0;
                end
                if (32'(pos_hi) < BITMAP_BYTES) begin
                  valid_q[pos_hi[IdxW-1:0]] <= 1'b0;
                end
                state_q <= ST_SCAN;
              end
              srbt_pkg::REQ_CLEAR_ALL: begin
                valid_q <= '0;
                state_q <= ST_SCAN;
              end
              default: begin
                state_q <= ST_SCAN;
              end
            endcase
          end
        end
        ST_MARK: begin
          // Already-set wins, then the vector segment, then write or erase.
          if (cur_bit) begin
            already_q <= 1'b1;
          end else if ({1'b0, seg_q} == total_q) begin
            vec_q <= 1'b1;
          end else if (!wok_q) begin
            erase_q <= 1'b1;
          end
          if (wr_en) begin
            valid_q[seg_idx] <= 1'b1;
          end
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_q == LastIdx) begin
            state_q <= ST_FIN;
          end else begin
            scan_q <= scan_q + IdxW'(1);
          end
        end
        ST_FIN: begin
          if (load) begin
            out_vld_q    <= 1'b1;
            o_already_q  <= already_q;
            o_erase_q    <= erase_q;
            o_vec_q      <= vec_q;
            o_count_q    <= srbt_pkg::CountW'(count_q);
            o_complete_q <= complete_q;
            o_near_q     <= nde_q && (remain_w <= thr_w);
            o_found_q    <= found_q || tail_found;
            if (found_q) begin
              o_next_q <= next_q;
            end else if (tail_found) begin
              o_next_q <= total_q + srbt_pkg::TotalW'(1);
            end else begin
              o_next_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign rsp_o.valid              = out_vld_q;
  assign rsp_o.already_received   = o_already_q;
  assign rsp_o.erase_request      = o_erase_q;
  assign rsp_o.vector_ready       = o_vec_q;
  assign rsp_o.received_count     = o_count_q;
  assign rsp_o.all_complete       = o_complete_q;
  assign rsp_o.near_done          = o_near_q;
  assign rsp_o.next_found         = o_found_q;
  assign rsp_o.next_missing_index = o_next_q;

  // A scan byte is only in flight right after a scan read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == ST_SCAN))
    else $error("scan data pending without a scan read");

  // The bitmap is written back only during the mark update step, and the written byte is then marked valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(seg_idx)])
    else $error("written bitmap byte not marked valid");

  // A missing segment inside the scanned bytes rules out completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> !complete_q)
    else $error("first missing segment found on a complete bitmap");

  // A result is loaded only once the last scan byte has been counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN) && !$past(pend_q))
    else $error("result loaded before the scan finished");

endmodule

/* sim/segment_receipt_bitmap_tracker_core_tb.sv */
// Self-checking testbench for segment_receipt_bitmap_tracker_core.
// Drives requests and APB register writes, predicts each result from a shadow bitmap.
// Depends on srbt_pkg, srbt_req_if / srbt_rsp_if and the tracker core.
`timescale 1ns / 1ps

module segment_receipt_bitmap_tracker_core_tb;

  localparam int unsigned MapBytes     = srbt_pkg::BitmapBytesDefault;
  localparam int unsigned SettleCycles = MapBytes + 8;
  localparam int unsigned ReqTarget    = 650;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned MaxPrinted   = 40;

  // One request as seen on the request channel.
  typedef struct packed {
    srbt_pkg::req_type_e            kind;
    logic [srbt_pkg::SegIndexW-1:0] seg;
    logic                           ok;
    logic [srbt_pkg::BytePosW-1:0]  pos;
  } seg_req_t;

  // One result as seen on the result channel.
  typedef struct packed {
    logic                         already;
    logic                         erase;
    logic                         vec;
    logic [srbt_pkg::CountW-1:0]  count;
    logic                         complete;
    logic                         near;
    logic                         found;
    logic [srbt_pkg::NextW-1:0]   next;
  } receipt_status_t;

  // Receiver behavior over a span of cycles.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_LONG_STALL
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [srbt_pkg::ApbAddrW-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  srbt_req_if req_ch ();
  srbt_rsp_if rsp_ch ();

  segment_receipt_bitmap_tracker_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the bitmap and the configuration.
  logic [7:0]                  receipt_map [MapBytes];
  logic [srbt_pkg::TotalW-1:0] total_cfg;
  logic                        near_en;

  seg_req_t        pending_reqs[$];
  receipt_status_t expected_status[$];

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned reqs_queued;
  int unsigned results_seen;
  int unsigned config_cnt;
  int unsigned n_marked, n_already, n_vector, n_erase;
  int unsigned n_complete, n_near, n_all_found;

  logic        took_req;
  int unsigned burst_left;
  int unsigned send_gap;
  rx_mode_e    rx_mode;
  int unsigned rx_span;
  int unsigned rx_hold;

  always #6 clk_i = ~clk_i;

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic flag_error(input string msg);
    if (err_cnt < MaxPrinted) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic note_field(input string name, input logic [31:0] got,
                            input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Applies one request to the shadow bitmap and works out the result.
  function automatic receipt_status_t predict_status(input seg_req_t r);
    receipt_status_t s;
    int unsigned     byte_idx;
    int unsigned     cnt;
    int unsigned     whole_bytes;
    int unsigned     scanned;
    int unsigned     remaining;
    int unsigned     threshold;
    s = '0;
    byte_idx = r.seg >> 3;
    case (r.kind)
      srbt_pkg::REQ_MARK: begin
        if (byte_idx < MapBytes && receipt_map[byte_idx][r.seg[2:0]]) begin
          s.already = 1'b1;
        end else if ({1'b0, r.seg} == total_cfg) begin
          s.vec = 1'b1;
        end else if (r.ok) begin
          if (byte_idx < MapBytes) begin
            receipt_map[byte_idx][r.seg[2:0]] = 1'b1;
          end
        end else begin
          s.erase = 1'b1;
        end
      end
      srbt_pkg::REQ_CLEAR_TWO: begin
        // The second byte of the pair may fall past the end of the bitmap.
        if (r.pos < MapBytes) begin
          receipt_map[r.pos] = 8'h00;
        end
        if (r.pos + 1 < MapBytes) begin
          receipt_map[r.pos + 1] = 8'h00;
        end
      end
      srbt_pkg::REQ_CLEAR_ALL: begin
        foreach (receipt_map[i]) begin
          receipt_map[i] = 8'h00;
        end
      end
      default: ;
    endcase

    cnt = 0;
    foreach (receipt_map[i]) begin
      for (int k = 0; k < 8; k++) begin
        cnt += receipt_map[i][k];
      end
    end
    s.count = srbt_pkg::CountW'(cnt);

    // Only whole bytes below total/8 take part in completion and the search.
    whole_bytes = total_cfg >> 3;
    if (whole_bytes > MapBytes) begin
      whole_bytes = MapBytes;
    end
    s.complete = 1'b1;
    for (int i = 0; i < whole_bytes; i++) begin
      if (receipt_map[i] != srbt_pkg::ByteFull) begin
        s.complete = 1'b0;
      end
    end

    if (total_cfg != 0) begin
      scanned = 0;
      for (int i = 0; i < whole_bytes && !s.found; i++) begin
        for (int k = 0; k < 8 && !s.found; k++) begin
          if (!receipt_map[i][k]) begin
            s.found = 1'b1;
            s.next  = srbt_pkg::NextW'(i * 8 + k + 1);
          end else begin
            scanned++;
          end
        end
      end
      // A partial last byte leaves scanned short of the total: nothing found.
      if (!s.found && scanned == total_cfg) begin
        s.found = 1'b1;
        s.next  = srbt_pkg::NextW'(total_cfg + 1);
      end
    end

    if (near_en) begin
      remaining = (cnt >= total_cfg) ? 0 : total_cfg - cnt;
      threshold = (total_cfg * 5) / 100;
      s.near = (remaining <= threshold);
    end
    return s;
  endfunction

  // Counts clock cycles and stops the run at the cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Request and result monitor: predicts at each request transfer, checks each result.
  always @(posedge clk_i) begin : monitor_p
    seg_req_t        r;
    receipt_status_t want;
    receipt_status_t got;
    if (rst_ni) begin
      took_req <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        r.kind = srbt_pkg::req_type_e'(req_ch.req_type);
        r.seg  = req_ch.seg_index;
        r.ok   = req_ch.write_ok;
        r.pos  = req_ch.byte_pos;
        want = predict_status(r);
        expected_status.push_back(want);
        n_marked    += (r.kind == srbt_pkg::REQ_MARK && !want.already && !want.vec &&
                        !want.erase);
        n_already   += want.already;
        n_vector    += want.vec;
        n_erase     += want.erase;
        n_complete  += (want.complete && total_cfg >= 8);
        n_near      += want.near;
        n_all_found += (want.found && want.next == total_cfg + 1);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        got.already  = rsp_ch.already_received;
        got.erase    = rsp_ch.erase_request;
        got.vec      = rsp_ch.vector_ready;
        got.count    = rsp_ch.received_count;
        got.complete = rsp_ch.all_complete;
        got.near     = rsp_ch.near_done;
        got.found    = rsp_ch.next_found;
        got.next     = rsp_ch.next_missing_index;
        if (expected_status.size() == 0) begin
          flag_error("result transfer with nothing expected");
        end else begin
          want = expected_status.pop_front();
          note_field("already_received", got.already, want.already);
          note_field("erase_request", got.erase, want.erase);
          note_field("vector_ready", got.vec, want.vec);
          note_field("received_count", got.count, want.count);
          note_field("all_complete", got.complete, want.complete);
          note_field("near_done", got.near, want.near);
          note_field("next_found", got.found, want.found);
          note_field("next_missing_index", got.next, want.next);
        end
      end
    end
  end

  // Request driver: bursts of transfers separated by random gaps.
  always @(negedge clk_i) begin : sender_p
    seg_req_t nxt;
    if (!req_ch.valid || took_req) begin
      if (send_gap > 0 || pending_reqs.size() == 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= srbt_pkg::ReqTypeW'($urandom_range(0, 3));
        req_ch.seg_index <= srbt_pkg::SegIndexW'($urandom_range(0, 511));
        req_ch.write_ok  <= 1'($urandom_range(0, 1));
        req_ch.byte_pos  <= srbt_pkg::BytePosW'($urandom_range(0, 63));
      end else begin
        nxt = pending_reqs.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= nxt.kind;
        req_ch.seg_index <= nxt.seg;
        req_ch.write_ok  <= nxt.ok;
        req_ch.byte_pos  <= nxt.pos;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 140);
        end
      end
    end
  end

  // Result receiver: switches at random between stall patterns.
  always @(negedge clk_i) begin : receiver_p
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(50, 400);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_ALWAYS: rsp_ch.ready <= 1'b1;
      RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rsp_ch.ready <= (cycle_cnt % 7 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) begin
            rx_hold = $urandom_range(1, 150);
          end
        end
      end
    endcase
  end

  // One APB transfer: setup phase, then access phase until pready.
  task automatic apb_access(input logic wr, input int unsigned idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= srbt_pkg::ApbAddrW'(idx * 4);
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register and reads it back.
  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== value) begin
      flag_error($sformatf("register %0d read %0h expected %0h", idx, rd, value));
    end
  endtask

  // Only called while no request is in flight.
  task automatic configure(input int unsigned total, input bit near);
    total_cfg = srbt_pkg::TotalW'(total);
    near_en   = near;
    write_reg(srbt_pkg::RegTotal, 32'(total));
    write_reg(srbt_pkg::RegNearDone, 32'(near));
    config_cnt++;
    @(posedge clk_i);
  endtask

  task automatic add_req(input srbt_pkg::req_type_e kind, input int unsigned seg, input bit ok,
                         input int unsigned pos);
    seg_req_t r;
    r.kind = kind;
    r.seg  = srbt_pkg::SegIndexW'(seg);
    r.ok   = ok;
    r.pos  = srbt_pkg::BytePosW'(pos);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Waits for every expected result, then lets the block settle.
  task automatic drain();
    while (results_seen != reqs_queued) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // One configuration followed by a mostly well-formed fill of the segments.
  task automatic run_random_phase();
    int unsigned total;
    int unsigned len;
    int unsigned pick;
    int unsigned idx;
    int unsigned pool[$];
    seg_req_t    r;
    pick = $urandom_range(0, 99);
    if (pick < 8) total = 0;
    else if (pick < 30) total = $urandom_range(1, 19);
    else if (pick < 75) total = $urandom_range(20, 80);
    else if (pick < 85) total = 512;
    else total = $urandom_range(0, 512);
    configure(total, 1'($urandom_range(0, 1)));

    // Usually start from an empty bitmap; sometimes keep leftovers.
    if ($urandom_range(0, 3) != 0) begin
      add_req(srbt_pkg::REQ_CLEAR_ALL, $urandom_range(0, 511), 1'($urandom_range(0, 1)),
              $urandom_range(0, 63));
    end
    for (int s = 0; s < total; s++) begin
      pool.push_back(s);
    end
    if (total == 0) len = 12;
    else if (total > 100) len = $urandom_range(20, 60);
    else len = total + total / 4 + 4;

    repeat (len) begin
      pick   = $urandom_range(0, 99);
      r.kind = srbt_pkg::req_type_e'($urandom_range(0, 3));
      r.seg  = srbt_pkg::SegIndexW'($urandom_range(0, 511));
      r.ok   = 1'($urandom_range(0, 1));
      r.pos  = srbt_pkg::BytePosW'($urandom_range(0, 63));
      if (pick < 72 && pool.size() > 0) begin
        // A fresh segment; a failed write leaves it for a later retry.
        idx    = $urandom_range(0, pool.size() - 1);
        r.kind = srbt_pkg::REQ_MARK;
        r.seg  = srbt_pkg::SegIndexW'(pool[idx]);
        r.ok   = ($urandom_range(0, 9) != 0);
        if (r.ok) begin
          pool.delete(idx);
        end
      end else if (pick < 80) begin
        // The vector segment, or a segment that may already be in.
        r.kind = srbt_pkg::REQ_MARK;
        if (pick < 76 && total < 512) begin
          r.seg = srbt_pkg::SegIndexW'(total);
        end else if (total > 0) begin
          r.seg = srbt_pkg::SegIndexW'($urandom_range(0, total - 1));
        end
      end else if (pick < 86) begin
        r.kind = srbt_pkg::REQ_QUERY;
      end else if (pick < 91) begin
        r.kind = srbt_pkg::REQ_CLEAR_TWO;
      end else if (pick < 93) begin
        r.kind = srbt_pkg::REQ_CLEAR_ALL;
      end
      add_req(r.kind, r.seg, r.ok, r.pos);
    end
    drain();
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = '0;
    req_ch.seg_index = '0;
    req_ch.write_ok  = 1'b0;
    req_ch.byte_pos  = '0;
    rsp_ch.ready     = 1'b0;
    took_req         = 1'b0;
    total_cfg        = '0;
    near_en          = 1'b0;
    foreach (receipt_map[i]) begin
      receipt_map[i] = 8'h00;
    end
    cycle_cnt    = 0;
    err_cnt      = 0;
    reqs_queued  = 0;
    results_seen = 0;
    config_cnt   = 0;
    n_marked     = 0;
    n_already    = 0;
    n_vector     = 0;
    n_erase      = 0;
    n_complete   = 0;
    n_near       = 0;
    n_all_found  = 0;
    burst_left   = 1;
    send_gap     = 0;
    rx_mode      = RX_ALWAYS;
    rx_span      = 0;
    rx_hold      = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty query, first mark, repeat, vector, failed write, top segment, end-of-map clears.
    configure(16, 1'b1);
    add_req(srbt_pkg::REQ_QUERY, 0, 1'b0, 0);
    add_req(srbt_pkg::REQ_MARK, 0, 1'b1, 0);
    add_req(srbt_pkg::REQ_MARK, 0, 1'b1, 63);
    add_req(srbt_pkg::REQ_MARK, 16, 1'b1, 0);
    add_req(srbt_pkg::REQ_MARK, 3, 1'b0, 0);
    add_req(srbt_pkg::REQ_MARK, 511, 1'b1, 0);
    add_req(srbt_pkg::REQ_CLEAR_TWO, 511, 1'b1, 63);
    add_req(srbt_pkg::REQ_MARK, 511, 1'b1, 0);
    add_req(srbt_pkg::REQ_CLEAR_TWO, 0, 1'b0, 62);
    add_req(srbt_pkg::REQ_CLEAR_TWO, 0, 1'b0, 0);
    add_req(srbt_pkg::REQ_CLEAR_ALL, 511, 1'b1, 63);
    drain();

    // Zero total: segment zero is the vector and nothing is ever found.
    configure(0, 1'b1);
    add_req(srbt_pkg::REQ_MARK, 0, 1'b1, 0);
    add_req(srbt_pkg::REQ_MARK, 7, 1'b1, 0);
    add_req(srbt_pkg::REQ_QUERY, 511, 1'b1, 63);
    drain();

    // Total below one byte: no whole byte to scan, so no missing segment is reported.
    configure(4, 1'b0);
    for (int s = 0; s < 4; s++) begin
      add_req(srbt_pkg::REQ_MARK, s, 1'b1, 0);
    end
    drain();

    // Largest total with the flag on.
    configure(512, 1'b1);
    add_req(srbt_pkg::REQ_MARK, 511, 1'b1, 0);
    add_req(srbt_pkg::REQ_MARK, 256, 1'b0, 0);
    add_req(srbt_pkg::REQ_QUERY, 0, 1'b0, 0);
    add_req(srbt_pkg::REQ_CLEAR_TWO, 0, 1'b0, 31);
    add_req(srbt_pkg::REQ_CLEAR_ALL, 0, 1'b0, 0);
    drain();

    while (reqs_queued < ReqTarget) begin
      run_random_phase();
    end

    if (expected_status.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_status.size()));
    end
    $display("Run covered %0d requests over %0d configurations in %0d cycles.",
             reqs_queued, config_cnt, cycle_cnt);
    $display("Marks set %0d, repeats %0d, vector %0d, erase %0d; %s %0d, near %0d, all %0d.",
             n_marked, n_already, n_vector, n_erase, "complete", n_complete, n_near,
             n_all_found);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
